// File: rtl/core/wsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wsp_pkg;

  localparam int unsigned QBITS   = 33;
  localparam int unsigned SCALE_W = 14;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned ADDR_W  = 6;

  typedef enum logic [2:0] {
    REG_ROW_X0  = 3'd0,
    REG_ROW_X1  = 3'd1,
    REG_ROW_Y0  = 3'd2,
    REG_ROW_Y1  = 3'd3,
    REG_ROW_W0  = 3'd4,
    REG_ROW_W1  = 3'd5,
    REG_WIDTH   = 3'd6,
    REG_HEIGHT  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic in_front;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } flags_t;

endpackage
`default_nettype wire

// File: rtl/core/world_to_screen_projection_core.sv
// pipeline: 5 front stages, 33 divider cells, one output register; throughput: one point
// per cycle while the receiver does not stall the output, set by the divider cell chain
// that retires one quotient bit per cell per cycle
// reset: asynchronous active low, empties the pipeline, matrix registers clear to zero,
// viewport resets to 1920 x 1080
`timescale 1ns / 1ps
`default_nettype none
module world_to_screen_projection_core import wsp_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] world_x_i,
  input  wire logic signed [31:0] world_y_i,
  input  wire logic signed [31:0] world_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    in_front_o,
  output logic signed [31:0]      screen_x_o,
  output logic signed [31:0]      screen_y_o
);

  localparam int unsigned DW = 67 - FRAC_BITS;
  localparam int unsigned NW = DW + SCALE_W + FRAC_BITS;
  localparam int unsigned RW = (NW > DW + QBITS) ? NW : DW + QBITS;

  logic [5:0][63:0]   rows_q;
  logic [SCALE_W-1:0] width_q, height_q;
  reg_idx_e           idx;
  logic               wr_en;

  assign idx    = reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= '0;
      width_q  <= SCALE_W'(1920);
      height_q <= SCALE_W'(1080);
    end else if (wr_en) begin
      unique case (idx)
        REG_WIDTH:  width_q  <= pwdata[SCALE_W-1:0];
        REG_HEIGHT: height_q <= pwdata[SCALE_W-1:0];
        default:    rows_q[paddr[5:3]] <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = DATA_W'(width_q);
      REG_HEIGHT: prdata = DATA_W'(height_q);
      default:    prdata = rows_q[paddr[5:3]];
    endcase
  end

  logic                 c_valid [QBITS+1];
  logic                 c_ready [QBITS+1];
  flags_t               c_flags [QBITS+1];
  logic [DW-1:0]        c_den   [QBITS+1];
  logic [RW-1:0]        c_rx    [QBITS+1];
  logic [RW-1:0]        c_ry    [QBITS+1];
  logic [QBITS-1:0]     c_qx    [QBITS+1];
  logic [QBITS-1:0]     c_qy    [QBITS+1];

  wsp_front #(
    .FRAC_BITS (FRAC_BITS),
    .DW        (DW),
    .RW        (RW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .x_i      (world_x_i),
    .y_i      (world_y_i),
    .z_i      (world_z_i),
    .rows_i   (rows_q),
    .width_i  (width_q),
    .height_i (height_q),
    .valid_o  (c_valid[0]),
    .ready_i  (c_ready[0]),
    .flags_o  (c_flags[0]),
    .den_o    (c_den[0]),
    .rem_x_o  (c_rx[0]),
    .rem_y_o  (c_ry[0])
  );

  assign c_qx[0] = '0;
  assign c_qy[0] = '0;

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    wsp_cell #(
      .DW  (DW),
      .RW  (RW),
      .BIT (QBITS - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[i]),
      .ready_o (c_ready[i]),
      .flags_i (c_flags[i]),
      .den_i   (c_den[i]),
      .rem_x_i (c_rx[i]),
      .rem_y_i (c_ry[i]),
      .q_x_i   (c_qx[i]),
      .q_y_i   (c_qy[i]),
      .valid_o (c_valid[i+1]),
      .ready_i (c_ready[i+1]),
      .flags_o (c_flags[i+1]),
      .den_o   (c_den[i+1]),
      .rem_x_o (c_rx[i+1]),
      .rem_y_o (c_ry[i+1]),
      .q_x_o   (c_qx[i+1]),
      .q_y_o   (c_qy[i+1])
    );
  end

  // round half up on the magnitude, saturate, apply sign
  function automatic logic [31:0] finish(input logic [QBITS-1:0] q, input logic [RW-1:0] rem,
                                         input logic [DW-1:0] den, input logic neg,
                                         input logic ovf);
    logic             up;
    logic [QBITS:0]   qr;
    logic [QBITS:0]   lim;
    logic [31:0]      v;
    up  = {rem[DW-1:0], 1'b0} >= {1'b0, den};
    qr  = {1'b0, q} + (QBITS+1)'(up);
    lim = neg ? (QBITS+1)'(64'h8000_0000) : (QBITS+1)'(64'h7FFF_FFFF);
    if (ovf || qr > lim) begin
      v = lim[31:0];
    end else begin
      v = qr[31:0];
    end
    return neg ? 32'(-v) : v;
  endfunction

  logic        out_en, out_valid_q, front_q;
  logic [31:0] sx_q, sy_q;
  flags_t      lf;

  assign lf              = c_flags[QBITS];
  assign out_en          = !out_valid_q || out_ready_i;
  assign c_ready[QBITS]  = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= c_valid[QBITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      front_q <= lf.in_front;
      sx_q    <= lf.in_front ? finish(c_qx[QBITS], c_rx[QBITS], c_den[QBITS], lf.neg_x,
                                      lf.ovf_x) : '0;
      sy_q    <= lf.in_front ? finish(c_qy[QBITS], c_ry[QBITS], c_den[QBITS], lf.neg_y,
                                      lf.ovf_y) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign in_front_o  = front_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;

  a_behind_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_front_o |-> screen_x_o == '0 && screen_y_o == '0)
    else $error("behind-camera beat with nonzero coordinates");

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_width_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en |=> $stable(width_q) && $stable(height_q))
    else $error("viewport changed without a write");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !c_ready[QBITS] |-> out_valid_o)
    else $error("divider chain stalled behind an empty output register");

endmodule
`default_nettype wire

// File: rtl/core/wsp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module wsp_front import wsp_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DW        = 51,
  parameter int unsigned RW        = 84
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire logic signed [31:0]         x_i,
  input  wire logic signed [31:0]         y_i,
  input  wire logic signed [31:0]         z_i,
  input  wire logic [5:0][63:0]           rows_i,
  input  wire logic [SCALE_W-1:0]         width_i,
  input  wire logic [SCALE_W-1:0]         height_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output flags_t                          flags_o,
  output logic [DW-1:0]                   den_o,
  output logic [RW-1:0]                   rem_x_o,
  output logic [RW-1:0]                   rem_y_o
);

  localparam int unsigned NS  = 5;
  localparam int unsigned CW  = 66 - FRAC_BITS;
  localparam int unsigned PW  = DW + SCALE_W;
  localparam int          THR = ((2 ** FRAC_BITS) + 999) / 1000;

  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  logic signed [31:0] coef [3][4];
  logic signed [31:0] pt   [3];

  logic signed [63:0] prod_q [3][3];
  logic signed [31:0] bias_q [3];

  logic signed [CW-1:0] clip_q [3];
  logic signed [CW-1:0] clip_d [3];

  flags_t        fc_q, fd_q, fe_q, fe_d;
  logic [DW-1:0] mag_x_q, mag_y_q, den_c_q, den_d_q, den_e_q;
  logic signed [DW-1:0] sx, sy;
  logic [PW-1:0] px, py;
  logic [RW-1:0] nx_q, ny_q, rx_q, ry_q;

  always_comb begin
    en[NS] = ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_comb begin
    pt[0] = x_i;
    pt[1] = y_i;
    pt[2] = z_i;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = rows_i[2*r + c/2][32*(c%2) +: 32];
      end
    end
  end

  // dot products, the constant-one column is exact
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= coef[r][c] * pt[c];
        end
        bias_q[r] <= coef[r][3];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      clip_d[r] = CW'(prod_q[r][0] >>> FRAC_BITS) + CW'(prod_q[r][1] >>> FRAC_BITS)
                + CW'(prod_q[r][2] >>> FRAC_BITS) + CW'(bias_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int r = 0; r < 3; r++) begin
        clip_q[r] <= clip_d[r];
      end
    end
  end

  assign sx = DW'(clip_q[2]) + DW'(clip_q[0]);
  assign sy = DW'(clip_q[2]) - DW'(clip_q[1]);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      fc_q.in_front <= clip_q[2] >= CW'(THR);
      fc_q.neg_x    <= sx[DW-1];
      fc_q.neg_y    <= sy[DW-1];
      fc_q.ovf_x    <= 1'b0;
      fc_q.ovf_y    <= 1'b0;
      mag_x_q       <= sx[DW-1] ? DW'(-sx) : DW'(sx);
      mag_y_q       <= sy[DW-1] ? DW'(-sy) : DW'(sy);
      den_c_q       <= DW'(clip_q[2]) << 1;
    end
  end

  assign px = PW'(mag_x_q) * PW'(width_i);
  assign py = PW'(mag_y_q) * PW'(height_i);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      fd_q    <= fc_q;
      den_d_q <= den_c_q;
      nx_q    <= RW'(px) << FRAC_BITS;
      ny_q    <= RW'(py) << FRAC_BITS;
    end
  end

  always_comb begin
    fe_d       = fd_q;
    fe_d.ovf_x = nx_q >= (RW'(den_d_q) << QBITS);
    fe_d.ovf_y = ny_q >= (RW'(den_d_q) << QBITS);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      fe_q    <= fe_d;
      den_e_q <= den_d_q;
      rx_q    <= nx_q;
      ry_q    <= ny_q;
    end
  end

  assign flags_o = fe_q;
  assign den_o   = den_e_q;
  assign rem_x_o = rx_q;
  assign rem_y_o = ry_q;

endmodule
`default_nettype wire

// File: rtl/core/wsp_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module wsp_cell import wsp_pkg::*; #(
  parameter int unsigned DW  = 51,
  parameter int unsigned RW  = 84,
  parameter int unsigned BIT = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire flags_t           flags_i,
  input  wire logic [DW-1:0]    den_i,
  input  wire logic [RW-1:0]    rem_x_i,
  input  wire logic [RW-1:0]    rem_y_i,
  input  wire logic [QBITS-1:0] q_x_i,
  input  wire logic [QBITS-1:0] q_y_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output flags_t                flags_o,
  output logic [DW-1:0]         den_o,
  output logic [RW-1:0]         rem_x_o,
  output logic [RW-1:0]         rem_y_o,
  output logic [QBITS-1:0]      q_x_o,
  output logic [QBITS-1:0]      q_y_o
);

  logic          v_q, en;
  logic [RW-1:0] dsh;
  logic          ge_x, ge_y;

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;

  assign dsh  = RW'(den_i) << BIT;
  assign ge_x = rem_x_i >= dsh;
  assign ge_y = rem_y_i >= dsh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flags_o <= flags_i;
      den_o   <= den_i;
      rem_x_o <= ge_x ? rem_x_i - dsh : rem_x_i;
      rem_y_o <= ge_y ? rem_y_i - dsh : rem_y_i;
      q_x_o   <= {q_x_i[QBITS-2:0], ge_x};
      q_y_o   <= {q_y_i[QBITS-2:0], ge_y};
    end
  end

endmodule
`default_nettype wire

// File: test/tb_world_to_screen_projection_core.sv
`timescale 1ns / 1ps
module tb_world_to_screen_projection_core;
  import wsp_pkg::*;

  localparam int unsigned FRAC       = 16;
  localparam int unsigned PIPE_DRAIN = 45;
  localparam int unsigned MAX_CYCLES = 400000;
  localparam int unsigned HOLD_LEN   = 300;

  typedef struct packed {
    logic        in_front;
    logic [31:0] sx;
    logic [31:0] sy;
  } proj_t;

  typedef struct {
    int unsigned grp;
    logic [31:0] x, y, z;
    bit          typed;
    proj_t       want;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic signed [31:0] world_x_i = '0, world_y_i = '0, world_z_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              in_front_o;
  logic signed [31:0] screen_x_o, screen_y_o;

  world_to_screen_projection_core #(.FRAC_BITS(FRAC)) u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mirror of the configured matrix and viewport
  logic signed [31:0] coef [12];
  logic [SCALE_W-1:0] vp_w, vp_h;

  proj_t       pending_points [$];
  int unsigned errors = 0;
  int unsigned send_idle = 0, recv_idle = 0;
  int unsigned cycles = 0;
  bit          hold_req = 0;
  logic        hold_on = 1'b0;

  function automatic longint signed clip_row(int r, logic signed [31:0] x,
                                             logic signed [31:0] y, logic signed [31:0] z);
    longint signed t0, t1, t2, t3;
    t0 = (longint'(coef[4*r])   * longint'(x)) >>> FRAC;
    t1 = (longint'(coef[4*r+1]) * longint'(y)) >>> FRAC;
    t2 = (longint'(coef[4*r+2]) * longint'(z)) >>> FRAC;
    t3 = (longint'(coef[4*r+3]) * (longint'(1) <<< FRAC)) >>> FRAC;
    return t0 + t1 + t2 + t3;
  endfunction

  function automatic logic [31:0] viewport_axis(logic [SCALE_W-1:0] sc, longint signed s,
                                                longint signed w);
    logic [127:0] mag, num, den, quo, rem, lim;
    bit neg;
    neg = s < 0;
    mag = {64'b0, neg ? 64'(-s) : 64'(s)};
    num = mag * ({114'b0, sc} << FRAC);
    den = {64'b0, 64'(w)} << 1;
    quo = num / den;
    rem = num % den;
    if (quo[127:64] == '0 && rem >= den - rem) quo = quo + 1;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (quo > lim) quo = lim;
    return neg ? -quo[31:0] : quo[31:0];
  endfunction

  function automatic proj_t project_point(logic signed [31:0] x, logic signed [31:0] y,
                                          logic signed [31:0] z);
    proj_t p;
    longint signed cx, cy, cw;
    cx = clip_row(0, x, y, z);
    cy = clip_row(1, x, y, z);
    cw = clip_row(2, x, y, z);
    p = '{1'b0, 32'h0, 32'h0};
    if (cw * 1000 >= (longint'(1) <<< FRAC)) begin
      p.in_front = 1'b1;
      p.sx = viewport_axis(vp_w, cw + cx, cw);
      p.sy = viewport_axis(vp_h, cw - cy, cw);
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_points.size() == 0) begin
          report_mismatch("unexpected beat", screen_x_o, 32'h0);
        end else begin
          proj_t e;
          e = pending_points.pop_front();
          if (in_front_o !== e.in_front) report_mismatch("in_front", in_front_o, e.in_front);
          if (screen_x_o !== e.sx) report_mismatch("screen_x", screen_x_o, e.sx);
          if (screen_y_o !== e.sy) report_mismatch("screen_y", screen_y_o, e.sy);
        end
      end
      out_ready_i <= !hold_on && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // long receiver hold-off to back the pipeline up
  initial begin
    forever begin
      wait (hold_req);
      @(posedge clk_i);
      hold_on <= 1'b1;
      repeat (HOLD_LEN) @(posedge clk_i);
      hold_on <= 1'b0;
      hold_req = 0;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("** world_to_screen_projection_core: FAILED **");
      $finish;
    end
  end

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 8);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WIDTH) vp_w = v[SCALE_W-1:0];
    else if (idx == REG_HEIGHT) vp_h = v[SCALE_W-1:0];
    else begin
      coef[2*int'(idx)]   = v[31:0];
      coef[2*int'(idx)+1] = v[63:32];
    end
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            bit typed, proj_t want);
    proj_t p;
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    world_x_i  <= x;
    world_y_i  <= y;
    world_z_i  <= z;
    do @(posedge clk_i); while (!in_ready_o);
    p = project_point(x, y, z);
    if (typed && p != want) begin
      $display("table row disagrees with prediction for %h %h %h", x, y, z);
      errors++;
    end
    pending_points.push_back(typed ? want : p);
  endtask

  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($urandom_range(0, 8 * 65536)) - 32'(4 * 65536);
  endfunction

  function automatic logic [31:0] rand_coord();
    int unsigned m;
    m = $urandom_range(0, 9);
    if (m < 7) return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
    if (m < 9) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic load_identity();
    write_reg(REG_ROW_X0, {32'h0, 32'h0001_0000});
    write_reg(REG_ROW_X1, 64'h0);
    write_reg(REG_ROW_Y0, {32'h0001_0000, 32'h0});
    write_reg(REG_ROW_Y1, 64'h0);
    write_reg(REG_ROW_W0, 64'h0);
    write_reg(REG_ROW_W1, {32'h0, 32'h0001_0000});
    write_reg(REG_WIDTH, 64'd1920);
    write_reg(REG_HEIGHT, 64'd1080);
  endtask

  task automatic load_random(int unsigned ph);
    logic [SCALE_W-1:0] wd [6] = '{14'd0, 14'd1, 14'd8192, 14'd16383, 14'd640, 14'd1};
    logic [SCALE_W-1:0] ht [6] = '{14'd8192, 14'd16383, 14'd1, 14'd0, 14'd480, 14'd1080};
    write_reg(REG_ROW_X0, {rand_coef(), rand_coef()});
    write_reg(REG_ROW_X1, {rand_coef(), rand_coef()});
    write_reg(REG_ROW_Y0, {rand_coef(), rand_coef()});
    write_reg(REG_ROW_Y1, {rand_coef(), rand_coef()});
    write_reg(REG_ROW_W0, {rand_coef(), rand_coef()});
    write_reg(REG_ROW_W1, {32'($urandom_range(1 << 16, 1 << 20)), rand_coef()});
    write_reg(REG_WIDTH, 64'(ph == 4 ? 14'($urandom) : wd[ph]));
    write_reg(REG_HEIGHT, 64'(ph == 4 ? 14'($urandom) : ht[ph]));
  endtask

  dir_row_t dir_tab [12] = '{
    '{0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, '{1'b0, 32'h0, 32'h0}},
    '{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, '{1'b0, 32'h0, 32'h0}},
    '{0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, '{1'b0, 32'h0, 32'h0}},
    '{0, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1, '{1'b0, 32'h0, 32'h0}},
    '{1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, '{1'b0, 32'h0, 32'h0}},
    '{1, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 1, '{1'b0, 32'h0, 32'h0}},
    '{1, 32'h0000_0000, 32'h0000_0000, 32'd65,        1, '{1'b0, 32'h0, 32'h0}},
    '{1, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1,
      '{1'b1, 32'h03C0_0000, 32'h021C_0000}},
    '{1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, '{1'b1, 32'h0780_0000, 32'h0}},
    '{1, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 1, '{1'b1, 32'h0, 32'h0438_0000}},
    '{1, 32'h7FFF_FFFF, 32'h0000_0000, 32'd66,        1,
      '{1'b1, 32'h7FFF_FFFF, 32'h021C_0000}},
    '{1, 32'h8000_0000, 32'h8000_0000, 32'd66,        1,
      '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF}}
  };

  initial begin
    proj_t none;
    int unsigned grp;
    none = '{1'b0, 32'h0, 32'h0};
    foreach (coef[i]) coef[i] = '0;
    vp_w = 14'd1920;
    vp_h = 14'd1080;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    grp = 0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].grp != grp) begin
        drain();
        load_identity();
        grp = dir_tab[i].grp;
      end
      send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].typed, dir_tab[i].want);
    end
    send_point(32'd66, 32'h0, 32'd66, 0, none);

    for (int unsigned ph = 0; ph < 6; ph++) begin
      drain();
      load_random(ph);
      send_idle = (ph < 2) ? 26 : (ph < 4) ? 62 : 0;
      recv_idle = (ph < 2) ? 62 : (ph < 4) ? 26 : 0;
      if (ph == 1 || ph == 5) hold_req = 1;
      repeat (82) send_point(rand_coord(), rand_coord(), rand_coord(), 0, none);
    end

    drain();
    if (errors == 0) begin
      $display("** world_to_screen_projection_core: PASSED **");
    end else begin
      $display("** world_to_screen_projection_core: FAILED **");
    end
    $finish;
  end

endmodule
